FILE: rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants of the slope limit relaxation cell
// Grid sizes, command and register codes, neighbour direction tables and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package slr_pkg;

	// Grid geometry; a cell address is {row, col}.
	localparam int MAX_ROWS = 256;
	localparam int MAX_COLS = 256;
	localparam int ROW_W    = 8;
	localparam int COL_W    = 8;
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int DIM_W    = 9;

	// Stored word: fixed flag over the elevation.
	localparam int ELEV_W = 32;
	localparam int WORD_W = ELEV_W + 1;
	localparam int LIM_W  = 31;

	localparam logic signed [ELEV_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;

	// Request commands; the unused code acts as a read.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_RELAX = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Configuration register indexes.
	localparam int          CFG_IDX_W    = 3;
	localparam int          CFG_DATA_W   = 31;
	localparam logic [2:0]  REG_ROWS     = 3'd0;
	localparam logic [2:0]  REG_COLS     = 3'd1;
	localparam logic [2:0]  REG_MODES    = 3'd2;
	localparam logic [2:0]  REG_ACROSS   = 3'd3;
	localparam logic [2:0]  REG_ALONG    = 3'd4;
	localparam logic [2:0]  REG_DIAGONAL = 3'd5;

	// Boundary codes; anything else skips the neighbour off that edge.
	localparam logic [1:0] MODE_FIXED    = 2'd0;
	localparam logic [1:0] MODE_PERIODIC = 2'd2;

	// Neighbour walk: eight directions, visited in table order.
	localparam int NBR_CNT   = 8;
	localparam int NBR_IDX_W = 3;
	localparam int NBR_CNT_W = 4;

	localparam logic signed [1:0] DIR_ROW [NBR_CNT] = '{
		2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1
	};
	localparam logic signed [1:0] DIR_COL [NBR_CNT] = '{
		2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1
	};

	// Which drop limit applies to each direction.
	localparam logic [1:0] LIM_ACROSS   = 2'd0;
	localparam logic [1:0] LIM_ALONG    = 2'd1;
	localparam logic [1:0] LIM_DIAGONAL = 2'd2;
	localparam logic [1:0] DIR_LIM [NBR_CNT] = '{
		LIM_ACROSS, LIM_DIAGONAL, LIM_ALONG, LIM_DIAGONAL,
		LIM_ACROSS, LIM_DIAGONAL, LIM_ALONG, LIM_DIAGONAL
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 latch_item;
		logic                 issue_ctr;
		logic                 latch_ctr;
		logic                 issue_nbr;
		logic [NBR_IDX_W-1:0] nbr_idx;
		logic                 acc;
		logic                 commit;
	} slr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_grid;
		logic is_load;
		logic is_relax;
		logic ctr_fixed;
	} slr_sts_t;

endpackage

FILE: rtl/slr_if.sv
// ----------------------------------------------------------------------------
// slr_if: request and result channels of the slope limit relaxation cell
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface slr_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           command;
	logic [slr_pkg::ROW_W-1:0]            row;
	logic [slr_pkg::COL_W-1:0]            col;
	logic signed [slr_pkg::ELEV_W-1:0]    elevation;
	logic                                 fixed_flag;

	modport source (output valid, command, row, col, elevation, fixed_flag, input ready);
	modport sink   (input valid, command, row, col, elevation, fixed_flag, output ready);
endinterface

interface slr_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [slr_pkg::ROW_W-1:0]            cell_row;
	logic [slr_pkg::COL_W-1:0]            cell_col;
	logic signed [slr_pkg::ELEV_W-1:0]    elevation_out;
	logic [slr_pkg::ELEV_W-1:0]           drop;
	logic                                 is_fixed;

	modport source (output valid, cell_row, cell_col, elevation_out, drop, is_fixed,
		input ready);
	modport sink   (input valid, cell_row, cell_col, elevation_out, drop, is_fixed,
		output ready);
endinterface

FILE: rtl/slope_limit_relax_cell.sv
// ----------------------------------------------------------------------------
// slope_limit_relax_cell: in-place slope limiting over a stored grid
// Loads, reads and relaxes single cells of a 256 x 256 grid of Q16.16
// elevations with fixed flags.
//
//   channel | direction | payload
//   req     | in        | command, row, col, elevation, fixed_flag
//   rsp     | out       | cell_row, cell_col, elevation_out, drop, is_fixed
//   cfg     | in        | cfg_we, cfg_index, cfg_data (write only)
//
// A load or an off-grid request goes from the check to the commit; a read or
// a fixed relax reads the centre first; a full relax reads the centre and then
// eight neighbours, one per cycle, on the single store port before one write.
// One request is in work at a time; the next is taken while a result waits.
// A full result register stalls the commit until rsp is ready.
// The store holds no reset value; reset clears only control and config.
// ----------------------------------------------------------------------------
module slope_limit_relax_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [slr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slr_pkg::CFG_DATA_W-1:0] cfg_data,
	slr_req_if.sink                        req,
	slr_rsp_if.source                      rsp
);

	slr_pkg::slr_cmd_t cmd;
	slr_pkg::slr_sts_t sts;

	// Sequencer.
	slr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Store and arithmetic.
	slr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_command    (req.command),
		.req_row        (req.row),
		.req_col        (req.col),
		.req_elevation  (req.elevation),
		.req_fixed_flag (req.fixed_flag),
		.cmd            (cmd),
		.sts            (sts),
		.cell_row       (rsp.cell_row),
		.cell_col       (rsp.cell_col),
		.elevation_out  (rsp.elevation_out),
		.drop           (rsp.drop),
		.is_fixed       (rsp.is_fixed)
	);

endmodule

FILE: rtl/slr_ctrl.sv
// ----------------------------------------------------------------------------
// slr_ctrl: sequencer of the slope limit relaxation cell
// Steps each request through check, centre read, neighbour walk and commit,
// and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module slr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  slr_pkg::slr_sts_t sts,
	output slr_pkg::slr_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_CTR   = 3'd2;
	localparam logic [2:0] ST_NBR   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]                       state_q, state_d;
	logic [slr_pkg::NBR_CNT_W-1:0]    k_q, k_d;
	logic                             out_valid_q;
	logic                             slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					state_d        = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.in_grid || sts.is_load) begin
					state_d = ST_FIN;
				end else begin
					cmd.issue_ctr = 1'b1;
					state_d       = ST_CTR;
				end
			end
			ST_CTR: begin
				cmd.latch_ctr = 1'b1;
				if (sts.is_relax && !sts.ctr_fixed) begin
					cmd.issue_nbr = 1'b1;
					cmd.nbr_idx   = '0;
					k_d           = slr_pkg::NBR_CNT_W'(1);
					state_d       = ST_NBR;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_NBR: begin
				// Fold in the previous neighbour while the next one is read.
				cmd.acc     = 1'b1;
				cmd.nbr_idx = k_q[slr_pkg::NBR_IDX_W-1:0];
				if (k_q == slr_pkg::NBR_CNT_W'(slr_pkg::NBR_CNT)) begin
					state_d = ST_FIN;
				end else begin
					cmd.issue_nbr = 1'b1;
					k_d           = k_q + slr_pkg::NBR_CNT_W'(1);
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, counter and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/slr_dp.sv
// ----------------------------------------------------------------------------
// slr_dp: datapath of the slope limit relaxation cell
// Configuration registers, the grid store, neighbour address generation,
// the saturating minimum and the result register.
// ----------------------------------------------------------------------------
module slr_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [slr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [slr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [1:0]                           req_command,
	input  logic [slr_pkg::ROW_W-1:0]            req_row,
	input  logic [slr_pkg::COL_W-1:0]            req_col,
	input  logic signed [slr_pkg::ELEV_W-1:0]    req_elevation,
	input  logic                                 req_fixed_flag,
	input  slr_pkg::slr_cmd_t                    cmd,
	output slr_pkg::slr_sts_t                    sts,
	output logic [slr_pkg::ROW_W-1:0]            cell_row,
	output logic [slr_pkg::COL_W-1:0]            cell_col,
	output logic signed [slr_pkg::ELEV_W-1:0]    elevation_out,
	output logic [slr_pkg::ELEV_W-1:0]           drop,
	output logic                                 is_fixed
);

	logic [slr_pkg::DIM_W-1:0]         rows_q, cols_q;
	logic [7:0]                        modes_q;
	logic [slr_pkg::LIM_W-1:0]         across_q, along_q, diag_q;

	logic [slr_pkg::DIM_W-1:0]         nrows, ncols;
	logic [slr_pkg::ROW_W-1:0]         last_row;
	logic [slr_pkg::COL_W-1:0]         last_col;
	logic                              fix_l, fix_r, fix_u, fix_d;
	logic                              per_l, per_r, per_u, per_d;
	logic                              bnd_fix;

	logic [1:0]                        cmd_q;
	logic [slr_pkg::ROW_W-1:0]         row_q;
	logic [slr_pkg::COL_W-1:0]         col_q;

	logic [slr_pkg::WORD_W-1:0]        mem [slr_pkg::DEPTH];
	logic [slr_pkg::WORD_W-1:0]        rd_q;
	logic [slr_pkg::ADDR_W-1:0]        mem_addr;
	logic                              mem_re, mem_we;

	logic signed [1:0]                 dr, dc;
	logic [slr_pkg::ROW_W-1:0]         nrow;
	logic [slr_pkg::COL_W-1:0]         ncol;
	logic                              nbr_ok;
	logic [slr_pkg::LIM_W-1:0]         nbr_lim;
	logic                              nbr_ok_s1;
	logic [slr_pkg::LIM_W-1:0]         lim_s1;

	logic signed [slr_pkg::ELEV_W+1:0] cand;
	logic signed [slr_pkg::ELEV_W-1:0] cand_sat;
	logic signed [slr_pkg::ELEV_W-1:0] orig_q, e0_q;
	logic                              fix_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= slr_pkg::DIM_W'(slr_pkg::MAX_ROWS);
			cols_q   <= slr_pkg::DIM_W'(slr_pkg::MAX_COLS);
			modes_q  <= '0;
			across_q <= '0;
			along_q  <= '0;
			diag_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				slr_pkg::REG_ROWS:     rows_q   <= cfg_data[slr_pkg::DIM_W-1:0];
				slr_pkg::REG_COLS:     cols_q   <= cfg_data[slr_pkg::DIM_W-1:0];
				slr_pkg::REG_MODES:    modes_q  <= cfg_data[7:0];
				slr_pkg::REG_ACROSS:   across_q <= cfg_data;
				slr_pkg::REG_ALONG:    along_q  <= cfg_data;
				slr_pkg::REG_DIAGONAL: diag_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Grid size clamped to the store, and the boundary codes per side.
	always_comb begin
		if (rows_q == '0) begin
			nrows = slr_pkg::DIM_W'(1);
		end else if (rows_q > slr_pkg::DIM_W'(slr_pkg::MAX_ROWS)) begin
			nrows = slr_pkg::DIM_W'(slr_pkg::MAX_ROWS);
		end else begin
			nrows = rows_q;
		end
		if (cols_q == '0) begin
			ncols = slr_pkg::DIM_W'(1);
		end else if (cols_q > slr_pkg::DIM_W'(slr_pkg::MAX_COLS)) begin
			ncols = slr_pkg::DIM_W'(slr_pkg::MAX_COLS);
		end else begin
			ncols = cols_q;
		end
	end

	assign last_row = slr_pkg::ROW_W'(nrows - slr_pkg::DIM_W'(1));
	assign last_col = slr_pkg::COL_W'(ncols - slr_pkg::DIM_W'(1));

	assign fix_l = (modes_q[1:0] == slr_pkg::MODE_FIXED);
	assign fix_r = (modes_q[3:2] == slr_pkg::MODE_FIXED);
	assign fix_u = (modes_q[5:4] == slr_pkg::MODE_FIXED);
	assign fix_d = (modes_q[7:6] == slr_pkg::MODE_FIXED);
	assign per_l = (modes_q[1:0] == slr_pkg::MODE_PERIODIC);
	assign per_r = (modes_q[3:2] == slr_pkg::MODE_PERIODIC);
	assign per_u = (modes_q[5:4] == slr_pkg::MODE_PERIODIC);
	assign per_d = (modes_q[7:6] == slr_pkg::MODE_PERIODIC);

	assign bnd_fix = (col_q == '0 && fix_l) || (col_q == last_col && fix_r) ||
		(row_q == '0 && fix_u) || (row_q == last_row && fix_d);

	// Request registers.
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			cmd_q <= req_command;
			row_q <= req_row;
			col_q <= req_col;
		end
	end

	// Status to the controller.
	assign sts.in_grid   = ({1'b0, row_q} < nrows) && ({1'b0, col_q} < ncols);
	assign sts.is_load   = (cmd_q == slr_pkg::CMD_LOAD);
	assign sts.is_relax  = (cmd_q == slr_pkg::CMD_RELAX);
	assign sts.ctr_fixed = rd_q[slr_pkg::ELEV_W] || (sts.is_relax && bnd_fix);

	// Neighbour address: step off the edge wraps under periodic, else skips.
	always_comb begin
		dr     = slr_pkg::DIR_ROW[cmd.nbr_idx];
		dc     = slr_pkg::DIR_COL[cmd.nbr_idx];
		nbr_ok = 1'b1;
		nrow   = row_q;
		ncol   = col_q;
		if (dr == -2'sd1) begin
			if (row_q == '0) begin
				nrow = last_row;
				if (!per_u) nbr_ok = 1'b0;
			end else begin
				nrow = row_q - slr_pkg::ROW_W'(1);
			end
		end else if (dr == 2'sd1) begin
			if (row_q == last_row) begin
				nrow = '0;
				if (!per_d) nbr_ok = 1'b0;
			end else begin
				nrow = row_q + slr_pkg::ROW_W'(1);
			end
		end
		if (dc == -2'sd1) begin
			if (col_q == '0) begin
				ncol = last_col;
				if (!per_l) nbr_ok = 1'b0;
			end else begin
				ncol = col_q - slr_pkg::COL_W'(1);
			end
		end else if (dc == 2'sd1) begin
			if (col_q == last_col) begin
				ncol = '0;
				if (!per_r) nbr_ok = 1'b0;
			end else begin
				ncol = col_q + slr_pkg::COL_W'(1);
			end
		end
		case (slr_pkg::DIR_LIM[cmd.nbr_idx])
			slr_pkg::LIM_ACROSS: nbr_lim = across_q;
			slr_pkg::LIM_ALONG:  nbr_lim = along_q;
			default:             nbr_lim = diag_q;
		endcase
	end

	// Single-port grid store holding {fixed, elevation}.
	assign mem_addr = cmd.issue_nbr ? {nrow, ncol} : {row_q, col_q};
	assign mem_re   = cmd.issue_ctr || cmd.issue_nbr;
	assign mem_we   = cmd.commit && sts.in_grid && (sts.is_load || sts.is_relax);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= {fix_q, e0_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Skip flag and drop limit travel with the read in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbr_ok_s1 <= 1'b0;
		end else if (cmd.issue_nbr) begin
			nbr_ok_s1 <= nbr_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_nbr) begin
			lim_s1 <= nbr_lim;
		end
	end

	// Neighbour plus limit, saturated at the largest elevation.
	always_comb begin
		cand = {{2{rd_q[slr_pkg::ELEV_W-1]}}, rd_q[slr_pkg::ELEV_W-1:0]} +
			(slr_pkg::ELEV_W+2)'(lim_s1);
		if (cand > (slr_pkg::ELEV_W+2)'(slr_pkg::SAT_MAX)) begin
			cand_sat = slr_pkg::SAT_MAX;
		end else begin
			cand_sat = cand[slr_pkg::ELEV_W-1:0];
		end
	end

	// Working elevation, original elevation and fixed flag of the cell.
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			orig_q <= req_elevation;
			e0_q   <= req_elevation;
			fix_q  <= req_fixed_flag;
		end else if (cmd.latch_ctr) begin
			orig_q <= rd_q[slr_pkg::ELEV_W-1:0];
			e0_q   <= rd_q[slr_pkg::ELEV_W-1:0];
			fix_q  <= sts.ctr_fixed;
		end else if (cmd.acc && nbr_ok_s1 && (cand_sat < e0_q)) begin
			e0_q <= cand_sat;
		end
	end

	// Result register; a cell outside the grid reports zeros.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			cell_row <= row_q;
			cell_col <= col_q;
			if (sts.in_grid) begin
				elevation_out <= e0_q;
				drop          <= orig_q - e0_q;
				is_fixed      <= fix_q;
			end else begin
				elevation_out <= '0;
				drop          <= '0;
				is_fixed      <= 1'b0;
			end
		end
	end

endmodule
